[rtl/core/mspc_pkg.sv]
// ----------------------------------------------------------------------------
// mspc_pkg
// Shared types and constants of the multichannel PID speed controller.
// ----------------------------------------------------------------------------
package mspc_pkg;

  // Number of controlled channels and fraction bits of measured/setpoint.
  localparam int CHANNELS  = 6;
  localparam int FRAC_BITS = 8;
  localparam int GAIN_FRAC = 8;

  // Field widths.
  localparam int CHAN_W   = 3;
  localparam int DATA_W   = 24;
  localparam int ERR_W    = DATA_W + 1;
  localparam int INTEG_W  = 24;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int GAIN_W   = 16;
  localparam int DB_W     = 16;
  localparam int ILIM_W   = 23;
  localparam int OLIM_W   = 15;
  localparam int DRIVE_W  = 16;

  // Channel index into the per-channel state.
  localparam int CH_LOG2  = (CHANNELS <= 2) ? 1 : $clog2(CHANNELS);
  localparam int CH_IDX_W = (CH_LOG2 > CHAN_W) ? CHAN_W : CH_LOG2;

  // Datapath widths of the back end.
  localparam int PP_W   = GAIN_W + 1 + ERR_W;
  localparam int PI_W   = GAIN_W + 1 + INTEG_W;
  localparam int PD_W   = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W  = PD_W + 1;
  localparam int SHIFT  = FRAC_BITS + GAIN_FRAC;
  localparam int MAG_W  = ACC_W - SHIFT;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd6;

  // Queue between front and back end.
  localparam int IQ_DEPTH = 2;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = IQ_PTR_W + 1;

  // Result queue.
  localparam int RQ_DEPTH = 8;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = RQ_PTR_W + 1;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DB_W-1:0]   dead_band;
    logic [ILIM_W-1:0] integral_limit;
    logic [OLIM_W-1:0] output_limit;
    logic              invert_sign;
  } cfg_t;

  // A classified sample: channel valid flag, channel and control error.
  typedef struct packed {
    logic                    ok;
    logic [CHAN_W-1:0]       ch;
    logic signed [ERR_W-1:0] err;
  } item_t;

endpackage

[rtl/core/mspc_front.sv]
// ----------------------------------------------------------------------------
// mspc_front
// Input side: applies the dead band, forms the error and checks the channel.
// ----------------------------------------------------------------------------
module mspc_front (
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [mspc_pkg::CHAN_W-1:0]         in_channel,
  input  logic signed [mspc_pkg::DATA_W-1:0]  in_measured,
  input  logic signed [mspc_pkg::DATA_W-1:0]  in_setpoint,
  input  mspc_pkg::cfg_t                      cfg,
  input  logic                                iq_full,
  output logic                                iq_push,
  output mspc_pkg::item_t                     iq_item
);

  logic signed [mspc_pkg::ERR_W-1:0] meas_x;
  logic signed [mspc_pkg::ERR_W-1:0] sp_x;
  logic [mspc_pkg::ERR_W-1:0]        meas_abs;
  logic                              in_dead;
  logic signed [mspc_pkg::ERR_W-1:0] meas_eff;

  assign meas_x   = {in_measured[mspc_pkg::DATA_W-1], in_measured};
  assign sp_x     = {in_setpoint[mspc_pkg::DATA_W-1], in_setpoint};
  assign meas_abs = meas_x[mspc_pkg::ERR_W-1] ? (~meas_x + 1'b1) : meas_x;
  assign in_dead  = meas_abs <
                    {{(mspc_pkg::ERR_W - mspc_pkg::DB_W){1'b0}}, cfg.dead_band};
  assign meas_eff = in_dead ? '0 : meas_x;

  assign iq_item.ok  = int'(in_channel) < mspc_pkg::CHANNELS;
  assign iq_item.ch  = in_channel;
  assign iq_item.err = sp_x - meas_eff;

  assign in_full = iq_full;
  assign iq_push = in_push & ~iq_full;

endmodule

[rtl/core/mspc_item_q.sv]
// ----------------------------------------------------------------------------
// mspc_item_q
// Short queue of classified samples between the front and the back end.
// ----------------------------------------------------------------------------
module mspc_item_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mspc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output mspc_pkg::item_t head
);

  mspc_pkg::item_t                 mem_r [mspc_pkg::IQ_DEPTH];
  logic [mspc_pkg::IQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mspc_pkg::IQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mspc_pkg::IQ_CNT_W-1:0]   count_r, count_nxt;

  assign full  = count_r == mspc_pkg::IQ_CNT_W'(mspc_pkg::IQ_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(mspc_pkg::IQ_CNT_W-1){1'b0}}, push}
                         - {{(mspc_pkg::IQ_CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/mspc_back.sv]
// ----------------------------------------------------------------------------
// mspc_back
// Control law pipeline: integral and derivative update, gain products,
// sum, truncation and output clamp.
// ----------------------------------------------------------------------------
module mspc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mspc_pkg::cfg_t                    cfg,
  input  logic                              iq_empty,
  input  mspc_pkg::item_t                   iq_head,
  output logic                              iq_pop,
  input  logic [mspc_pkg::RQ_CNT_W-1:0]     rq_count,
  output logic                              rq_push,
  output logic signed [mspc_pkg::DRIVE_W-1:0] rq_data
);

  localparam int OCC_W  = mspc_pkg::RQ_CNT_W + 1;
  localparam int ISUM_W = mspc_pkg::ERR_W + 1;

  // Per-channel state.
  logic signed [mspc_pkg::INTEG_W-1:0] integ_r [mspc_pkg::CHANNELS];
  logic signed [mspc_pkg::ERR_W-1:0]   prev_r  [mspc_pkg::CHANNELS];

  // Stage 1: state update.
  logic                                v1_r, ok1_r;
  logic signed [mspc_pkg::ERR_W-1:0]   err1_r;
  logic signed [mspc_pkg::INTEG_W-1:0] integ1_r;
  logic signed [mspc_pkg::DIFF_W-1:0]  diff1_r;

  // Stage 2: products.
  logic                                v2_r, ok2_r;
  logic signed [mspc_pkg::PP_W-1:0]    pp_r;
  logic signed [mspc_pkg::PI_W-1:0]    pi_r;
  logic signed [mspc_pkg::PD_W-1:0]    pd_r;

  // Stage 3: sum.
  logic                                v3_r, ok3_r;
  logic signed [mspc_pkg::ACC_W-1:0]   sum_r;

  logic [OCC_W-1:0]                    occ;
  logic                                issue;
  logic [mspc_pkg::CH_IDX_W-1:0]       idx;
  logic signed [ISUM_W-1:0]            isum;
  logic signed [ISUM_W-1:0]            ilim_pos;
  logic signed [ISUM_W-1:0]            ilim_neg;
  logic signed [mspc_pkg::INTEG_W-1:0] integ_nxt;
  logic signed [mspc_pkg::DIFF_W-1:0]  diff_nxt;
  logic signed [mspc_pkg::PP_W-1:0]    pp_nxt;
  logic signed [mspc_pkg::PI_W-1:0]    pi_nxt;
  logic signed [mspc_pkg::PD_W-1:0]    pd_nxt;
  logic signed [mspc_pkg::ACC_W-1:0]   sum_nxt;
  logic [mspc_pkg::ACC_W-1:0]          sum_abs;
  logic [mspc_pkg::MAG_W-1:0]          mag;
  logic [mspc_pkg::OLIM_W-1:0]         mag_clamp;
  logic                                drv_neg;
  logic signed [mspc_pkg::DRIVE_W-1:0] drv_pos;

  // An item is taken only when the result queue has room for it and for
  // everything already in flight, so the pipeline never has to stall.
  assign occ   = {1'b0, rq_count} + OCC_W'(v1_r) + OCC_W'(v2_r) + OCC_W'(v3_r);
  assign issue = ~iq_empty & (occ < OCC_W'(mspc_pkg::RQ_DEPTH));
  assign iq_pop = issue;

  assign idx = iq_head.ch[mspc_pkg::CH_IDX_W-1:0];

  always_comb begin
    isum = ISUM_W'(integ_r[idx]) + ISUM_W'(iq_head.err);
    ilim_pos = $signed({{(ISUM_W - mspc_pkg::ILIM_W){1'b0}}, cfg.integral_limit});
    ilim_neg = -ilim_pos;
    priority if (isum > ilim_pos) begin
      integ_nxt = ilim_pos[mspc_pkg::INTEG_W-1:0];
    end else if (isum < ilim_neg) begin
      integ_nxt = ilim_neg[mspc_pkg::INTEG_W-1:0];
    end else begin
      integ_nxt = isum[mspc_pkg::INTEG_W-1:0];
    end
    diff_nxt = mspc_pkg::DIFF_W'(iq_head.err) - mspc_pkg::DIFF_W'(prev_r[idx]);
  end

  always_comb begin
    pp_nxt = $signed({1'b0, cfg.gain_p}) * err1_r;
    pi_nxt = $signed({1'b0, cfg.gain_i}) * integ1_r;
    pd_nxt = $signed({1'b0, cfg.gain_d}) * diff1_r;
    sum_nxt = mspc_pkg::ACC_W'(pp_r) + mspc_pkg::ACC_W'(pi_r)
            + mspc_pkg::ACC_W'(pd_r);
  end

  // Truncation toward zero works on the magnitude; the sign is put back
  // after the clamp.
  always_comb begin
    sum_abs   = sum_r[mspc_pkg::ACC_W-1] ? (~sum_r + 1'b1) : sum_r;
    mag       = sum_abs[mspc_pkg::ACC_W-1:mspc_pkg::SHIFT];
    mag_clamp = (mag > {{(mspc_pkg::MAG_W - mspc_pkg::OLIM_W){1'b0}},
                        cfg.output_limit})
              ? cfg.output_limit : mag[mspc_pkg::OLIM_W-1:0];
    drv_neg   = sum_r[mspc_pkg::ACC_W-1] ^ cfg.invert_sign;
    drv_pos   = $signed({1'b0, mag_clamp});
    if (!ok3_r) begin
      rq_data = '0;
    end else if (drv_neg) begin
      rq_data = -drv_pos;
    end else begin
      rq_data = drv_pos;
    end
  end

  assign rq_push = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < mspc_pkg::CHANNELS; k++) begin
        integ_r[k] <= '0;
        prev_r[k]  <= '0;
      end
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (issue && iq_head.ok) begin
        integ_r[idx] <= integ_nxt;
        prev_r[idx]  <= iq_head.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok1_r    <= iq_head.ok;
    err1_r   <= iq_head.err;
    integ1_r <= integ_nxt;
    diff1_r  <= diff_nxt;
    ok2_r    <= ok1_r;
    pp_r     <= pp_nxt;
    pi_r     <= pi_nxt;
    pd_r     <= pd_nxt;
    ok3_r    <= ok2_r;
    sum_r    <= sum_nxt;
  end

endmodule

[rtl/core/mspc_result_q.sv]
// ----------------------------------------------------------------------------
// mspc_result_q
// Queue of finished drive values; its head is shown on the result ports.
// ----------------------------------------------------------------------------
module mspc_result_q (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic signed [mspc_pkg::DRIVE_W-1:0]  push_data,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [mspc_pkg::DRIVE_W-1:0]  head,
  output logic [mspc_pkg::RQ_CNT_W-1:0]        count
);

  logic signed [mspc_pkg::DRIVE_W-1:0] mem_r [mspc_pkg::RQ_DEPTH];
  logic [mspc_pkg::RQ_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mspc_pkg::RQ_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mspc_pkg::RQ_CNT_W-1:0]       count_r, count_nxt;
  logic                                do_pop;

  assign empty  = count_r == '0;
  assign head   = mem_r[rd_ptr_r];
  assign count  = count_r;
  assign do_pop = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(mspc_pkg::RQ_CNT_W-1){1'b0}}, push}
                         - {{(mspc_pkg::RQ_CNT_W-1){1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/multichannel_pid_speed_controller.sv]
// ----------------------------------------------------------------------------
// multichannel_pid_speed_controller
// PID controller for six channels with dead band, integral clamp and
// output clamp.
// ----------------------------------------------------------------------------
// The controller takes one sample per clock cycle while full is low and
// returns one drive value for each sample, in order. A sample passes through
// the sample queue, the state update, product and sum stages and the result
// queue to the result ports; the per-channel integral and previous error are
// read and written back in a single cycle, so samples for the same channel may
// follow each other without gaps. Up to eight results are held when the result
// side stalls, and full rises once the short sample queue behind the input has
// filled. A sample with a channel number of six or more gives a drive of zero
// and leaves all channel state untouched. Configuration writes are always
// ready and should be made only while no sample is in flight.
module multichannel_pid_speed_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [mspc_pkg::CHAN_W-1:0]           in_channel,
  input  logic signed [mspc_pkg::DATA_W-1:0]    in_measured,
  input  logic signed [mspc_pkg::DATA_W-1:0]    in_setpoint,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [mspc_pkg::DRIVE_W-1:0]   out_drive,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mspc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mspc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mspc_pkg::cfg_t                      cfg_r;
  logic                                iq_push, iq_full, iq_pop, iq_empty;
  mspc_pkg::item_t                     iq_in, iq_head;
  logic                                rq_push;
  logic signed [mspc_pkg::DRIVE_W-1:0] rq_data;
  logic [mspc_pkg::RQ_CNT_W-1:0]       rq_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mspc_pkg::REG_GAIN_P:     cfg_r.gain_p <= cfg_data[mspc_pkg::GAIN_W-1:0];
        mspc_pkg::REG_GAIN_I:     cfg_r.gain_i <= cfg_data[mspc_pkg::GAIN_W-1:0];
        mspc_pkg::REG_GAIN_D:     cfg_r.gain_d <= cfg_data[mspc_pkg::GAIN_W-1:0];
        mspc_pkg::REG_DEAD_BAND:  cfg_r.dead_band <= cfg_data[mspc_pkg::DB_W-1:0];
        mspc_pkg::REG_INTEG_LIM:  cfg_r.integral_limit <= cfg_data[mspc_pkg::ILIM_W-1:0];
        mspc_pkg::REG_OUTPUT_LIM: cfg_r.output_limit <= cfg_data[mspc_pkg::OLIM_W-1:0];
        mspc_pkg::REG_INVERT:     cfg_r.invert_sign <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mspc_front u_front (
    .in_push     (in_push),
    .in_full     (in_full),
    .in_channel  (in_channel),
    .in_measured (in_measured),
    .in_setpoint (in_setpoint),
    .cfg         (cfg_r),
    .iq_full     (iq_full),
    .iq_push     (iq_push),
    .iq_item     (iq_in)
  );

  mspc_item_q u_item_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (iq_push),
    .push_item (iq_in),
    .full      (iq_full),
    .pop       (iq_pop),
    .empty     (iq_empty),
    .head      (iq_head)
  );

  mspc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .iq_empty (iq_empty),
    .iq_head  (iq_head),
    .iq_pop   (iq_pop),
    .rq_count (rq_count),
    .rq_push  (rq_push),
    .rq_data  (rq_data)
  );

  mspc_result_q u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_drive),
    .count     (rq_count)
  );

endmodule

[tb/sv/multichannel_pid_speed_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_pid_speed_controller_tb
// Drives control samples into the six-channel PID controller and predicts
// every drive value with an independent integer model of the channel state.
// Directed cases cover the dead band, both clamps, truncation toward zero,
// sign inversion, field extremes and unused channels. Random traffic then
// runs under several register settings with random gaps and stalls.
// ----------------------------------------------------------------------------
module multichannel_pid_speed_controller_tb;
  import mspc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int SHIFT_BITS    = FRAC_BITS + GAIN_FRAC;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [CHAN_W-1:0] in_channel;
  logic signed [DATA_W-1:0] in_measured;
  logic signed [DATA_W-1:0] in_setpoint;
  logic out_empty;
  logic out_pop;
  logic signed [DRIVE_W-1:0] out_drive;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Register copies and per-channel controller state of the predictor.
  longint kp_m, ki_m, kd_m, dband_m, ilim_m, olim_m;
  bit invert_m;
  longint integ_m[CHANNELS];
  longint prev_err_m[CHANNELS];

  logic signed [DRIVE_W-1:0] expected_drive_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit gaps_in;
  bit gaps_out;

  multichannel_pid_speed_controller u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_channel  (in_channel),
    .in_measured (in_measured),
    .in_setpoint (in_setpoint),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_drive   (out_drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // Advances the channel state and returns the drive for one sample.
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    input logic [CHAN_W-1:0] ch,
    input logic signed [DATA_W-1:0] meas,
    input logic signed [DATA_W-1:0] target
  );
    longint m, e, integ, acc, drv;
    if (ch >= CHANNELS) return '0;
    m = meas;
    if ((m < 0 ? -m : m) < dband_m) m = 0;
    e = longint'(target) - m;
    integ = integ_m[ch] + e;
    if (integ > ilim_m) integ = ilim_m;
    if (integ < -ilim_m) integ = -ilim_m;
    acc = kp_m * e + ki_m * integ + kd_m * (e - prev_err_m[ch]);
    integ_m[ch] = integ;
    prev_err_m[ch] = e;
    if (invert_m) acc = -acc;
    // Shift the magnitude so that the result truncates toward zero.
    if (acc < 0) begin
      drv = -((-acc) >> SHIFT_BITS);
    end else begin
      drv = acc >> SHIFT_BITS;
    end
    if (drv > olim_m) drv = olim_m;
    if (drv < -olim_m) drv = -olim_m;
    return drv[DRIVE_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 8191)) - 4096;
      2: v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      default: begin
        // Straddle the dead band edge.
        v = int'(dband_m) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    int c;
    c = ($urandom_range(0, 9) < 9) ? $urandom_range(0, CHANNELS - 1)
                                   : $urandom_range(CHANNELS, 7);
    return c[CHAN_W-1:0];
  endfunction

  // Leaves in_push high after the transfer so that the next sample can
  // follow at the very next edge.
  task automatic send_sample(
    input logic [CHAN_W-1:0] ch,
    input logic signed [DATA_W-1:0] meas,
    input logic signed [DATA_W-1:0] target
  );
    int gap;
    gap = gaps_in ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push     <= 1'b1;
    in_channel  <= ch;
    in_measured <= meas;
    in_setpoint <= target;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_drive_q.push_back(predict_drive(ch, meas, target));
  endtask

  task automatic wait_for_results();
    in_push <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
  endtask

  // Leaves cfg_valid high; apply_settings lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_P:     kp_m = data[GAIN_W-1:0];
      REG_GAIN_I:     ki_m = data[GAIN_W-1:0];
      REG_GAIN_D:     kd_m = data[GAIN_W-1:0];
      REG_DEAD_BAND:  dband_m = data[DB_W-1:0];
      REG_INTEG_LIM:  ilim_m = data[ILIM_W-1:0];
      REG_OUTPUT_LIM: olim_m = data[OLIM_W-1:0];
      REG_INVERT:     invert_m = data[0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random values; they must be ignored, as
  // must the write to the index past the last register.
  task automatic apply_settings(input int kp, input int ki, input int kd,
                                input int db, input int il, input int ol,
                                input int inv);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_GAIN_P, {junk[6:0], kp[15:0]});
    write_reg(REG_GAIN_I, {junk[13:7], ki[15:0]});
    write_reg(REG_GAIN_D, {junk[20:14], kd[15:0]});
    write_reg(REG_DEAD_BAND, {junk[27:21], db[15:0]});
    write_reg(REG_INTEG_LIM, il[22:0]);
    write_reg(REG_OUTPUT_LIM, {junk[31:24], ol[14:0]});
    write_reg(REG_INVERT, {junk[21:0], inv[0]});
    write_reg(CFG_UNUSED_IDX, junk[22:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings(int'($urandom_range(0, 65535)) >> $urandom_range(0, 8),
                   int'($urandom_range(0, 65535)) >> $urandom_range(0, 8),
                   int'($urandom_range(0, 65535)) >> $urandom_range(0, 8),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2048),
                   $urandom_range(0, 1) ? $urandom_range(0, 8388607)
                                        : $urandom_range(0, 65535),
                   $urandom_range(0, 32767),
                   $urandom_range(0, 1));
  endtask

  // With every register at its reset value the drive must stay at zero.
  task automatic test_reset_defaults();
    send_sample(3'd0, 24'sd1000, 24'sd5000);
    send_sample(3'd5, -24'sd70000, 24'h7FFFFF);
    wait_for_results();
  endtask

  task automatic test_dead_band();
    apply_settings(16'h0100, 0, 0, 16'h0200, 0, 16'h7FFF, 0);
    send_sample(3'd0, 24'sd511, 24'h001000);
    send_sample(3'd0, 24'sd512, 24'h001000);
    send_sample(3'd0, -24'sd511, 24'h001000);
    send_sample(3'd0, -24'sd512, 24'h001000);
    send_sample(3'd0, 24'sd0, 24'h001000);
    wait_for_results();
  endtask

  task automatic test_integral_clamp();
    apply_settings(0, 16'h0100, 0, 0, 24'h000800, 16'h7FFF, 0);
    repeat (3) send_sample(3'd1, 24'sd0, 24'h000600);
    repeat (2) send_sample(3'd1, 24'sd0, -24'sd4096);
    wait_for_results();
  endtask

  // Both signs of output saturation, and small negative sums that must
  // truncate to zero rather than to minus one.
  task automatic test_output_clamp_and_truncation();
    apply_settings(16'h0100, 16'h0080, 16'h0040, 0, 24'h7FFFFF, 100, 0);
    send_sample(3'd2, 24'sd0, 24'h010000);
    send_sample(3'd2, 24'sd0, -24'sd131072);
    send_sample(3'd3, 24'sd0, -24'sd1);
    send_sample(3'd3, 24'sd0, 24'sd1);
    wait_for_results();
  endtask

  task automatic test_extremes_inverted();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 16'h7FFF, 1);
    send_sample(3'd4, 24'h800000, 24'h7FFFFF);
    send_sample(3'd4, 24'h7FFFFF, 24'h800000);
    send_sample(3'd5, 24'h800000, 24'h7FFFFF);
    send_sample(3'd6, 24'h7FFFFF, 24'h800000);
    send_sample(3'd7, 24'h800000, 24'h7FFFFF);
    send_sample(3'd0, 24'sd65534, 24'sd0);
    wait_for_results();
  endtask

  // The sender holds off until the result side has drained, then resumes.
  task automatic test_sender_hold_off();
    gaps_in  = 1'b0;
    gaps_out = 1'b1;
    apply_random_settings();
    repeat (10) send_sample(pick_channel(), pick_value(), pick_value());
    wait_for_results();
    repeat (10) send_sample(pick_channel(), pick_value(), pick_value());
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int count;
    for (int phase = 0; phase < 6; phase++) begin
      count = 110;
      case (phase)
        0: begin
          count = 100;
          gaps_in  = 1'b0;
          gaps_out = 1'b0;
          apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF,
                         16'h7FFF, 0);
        end
        1: begin
          count = 60;
          gaps_in  = 1'b1;
          gaps_out = 1'b1;
          apply_settings(1, 1, 1, 0, 1, 1, 1);
        end
        2: begin
          // Receiver stalls only, so the result queue fills and full rises.
          gaps_in  = 1'b0;
          gaps_out = 1'b1;
          apply_random_settings();
        end
        3: begin
          gaps_in  = 1'b1;
          gaps_out = 1'b0;
          apply_random_settings();
        end
        default: apply_random_settings();
      endcase
      for (int n = 0; n < count; n++) begin
        if (phase >= 4 && n % 25 == 0) begin
          gaps_in  = $urandom_range(0, 1);
          gaps_out = $urandom_range(0, 1);
        end
        send_sample(pick_channel(), pick_value(), pick_value());
      end
      wait_for_results();
    end
  endtask

  initial begin : result_side
    int stall;
    logic signed [DRIVE_W-1:0] want;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = gaps_out ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (expected_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: drive %0d", out_drive);
      end else begin
        want = expected_drive_q.pop_front();
        if (out_drive !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("drive mismatch: expected %0d, got %0d", want, out_drive);
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("multichannel_pid_speed_controller_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_push     <= 1'b0;
    in_channel  <= '0;
    in_measured <= '0;
    in_setpoint <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    gaps_in    = 1'b0;
    gaps_out   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_dead_band();
    test_integral_clamp();
    test_output_clamp_and_truncation();
    test_extremes_inverted();
    test_sender_hold_off();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_drive_q.size() == 0) begin
      $display("multichannel_pid_speed_controller_tb: done, clean");
    end else begin
      $display("multichannel_pid_speed_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
